// ----- rtl/time_bucket_aggregator_macros.svh -----
// Assertion macros used by the checker file of the time bucket aggregator.
// Both sample on the rising edge of i_clk and are quiet while i_rst_n is low.
`ifndef TIME_BUCKET_AGGREGATOR_MACROS_SVH
`define TIME_BUCKET_AGGREGATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tba_pkg.sv -----
package tba_pkg;

    // Field widths of the ports.
    localparam int TIME_W    = 32;
    localparam int OUT_VAL_W = 32;
    localparam int IN_VAL_W  = 32;

    // Significant bits of a sample value, and width of the per-data-set result count.
    localparam int VALUE_W = 32;
    localparam int LIMIT_W = 16;

    // Window accumulator and the shared bit-serial divider.
    localparam int SUM_W       = 64;
    localparam int ALIGN_STEPS = TIME_W;
    localparam int AVG_STEPS   = SUM_W;
    localparam int CNT_W       = $clog2(AVG_STEPS + 1);

    // Configuration registers.
    localparam int BUCKET_W      = 11;
    localparam int MODE_W        = 3;
    localparam int LIMIT_FIELD_W = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    localparam logic [LIMIT_FIELD_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Reduction modes; codes above MODE_SUM reduce as an average.
    localparam logic [MODE_W-1:0] MODE_RAW = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AVG = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAX = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUM = 3'd4;

    // Window length in seconds: up to 2047 minutes times 60 fits in 17 bits.
    localparam int SECS_W = 17;
    localparam logic [5:0] SECS_PER_MIN = 6'd60;

endpackage

// ----- rtl/time_bucket_aggregator.sv -----
// Time bucket aggregator: groups timestamped samples into tumbling windows aligned
// to window-length multiples; emits one reduced word per closed window, or per raw sample.
// Input channel: i_in_valid / o_in_stall carry sample_time, sample_value and
// end_of_data. Output channel: o_out_valid / i_out_stall carry out_time, out_value
// and last_of_run. The configuration port writes one register per i_cfg_we cycle.
// The block works on one sample at a time; o_in_stall is high while it does.
// A raw sample goes straight to the output stage, and a sample that joins the open
// window only updates its sum, extremes and count. Opening a window runs the shared
// divider 32 steps for the alignment remainder. Closing an average window adds 64
// divider steps for the quotient, so a sample that closes one window and flushes the
// next takes the longest. The divider produces one quotient bit per cycle.
// The output word sits in a register: a stalled receiver holds it there, and the
// block waits only when it has a further word to load into a full register.
// A synchronous reset closes the window, clears the result count and the output valid,
// and restores the registers to raw mode with the full result limit.
module time_bucket_aggregator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic        [tba_pkg::TIME_W-1:0]     i_sample_time,
    input  logic signed [tba_pkg::IN_VAL_W-1:0]   i_sample_value,
    input  logic                                  i_end_of_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic        [tba_pkg::TIME_W-1:0]     o_out_time,
    output logic signed [tba_pkg::OUT_VAL_W-1:0]  o_out_value,
    output logic                                  o_last_of_run,
    input  logic                                  i_cfg_we,
    input  logic        [tba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [tba_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_ALIGN_LD = 4'd2;
    localparam logic [3:0] S_ALIGN    = 4'd3;
    localparam logic [3:0] S_OPEN     = 4'd4;
    localparam logic [3:0] S_EOD      = 4'd5;
    localparam logic [3:0] S_EMIT     = 4'd6;
    localparam logic [3:0] S_AVG      = 4'd7;
    localparam logic [3:0] S_AVG_FIN  = 4'd8;
    localparam logic [3:0] S_PUSH     = 4'd9;
    localparam logic [3:0] S_CLOSE    = 4'd10;

    localparam int VW = tba_pkg::VALUE_W;
    localparam int SW = tba_pkg::SUM_W;
    localparam int TW = tba_pkg::TIME_W;
    localparam int LW = tba_pkg::LIMIT_W;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // Control state.
    logic [3:0]                 r_state, n_state;
    logic [3:0]                 r_ret, n_ret;
    logic                       r_open, n_open;
    logic [LW-1:0]              r_ec, n_ec;
    logic                       r_out_valid, n_out_valid;
    logic [tba_pkg::BUCKET_W-1:0] r_bucket;
    logic [tba_pkg::MODE_W-1:0] r_mode;
    logic [LW-1:0]              r_limit;

    // Item, window and divider data.
    logic [TW-1:0]              r_t, n_t;
    logic signed [VW-1:0]       r_v, n_v;
    logic                       r_eod, n_eod;
    logic                       r_raw, n_raw;
    logic [tba_pkg::SECS_W-1:0] r_secs, n_secs;
    logic                       r_more, n_more;
    logic [TW-1:0]              r_start, n_start;
    logic signed [SW-1:0]       r_sum, n_sum;
    logic signed [VW-1:0]       r_min, n_min;
    logic signed [VW-1:0]       r_max, n_max;
    logic [TW-1:0]              r_count, n_count;
    logic [TW-1:0]              r_first, n_first;
    logic [TW-1:0]              r_last_t, n_last_t;
    logic [TW-1:0]              r_res_time, n_res_time;
    logic signed [VW-1:0]       r_res_val, n_res_val;
    logic [TW-1:0]              r_rem, n_rem;
    logic [SW-1:0]              r_quo, n_quo;
    logic [TW-1:0]              r_divisor, n_divisor;
    logic [tba_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_neg, n_neg;
    logic [TW-1:0]              r_out_time, n_out_time;
    logic signed [tba_pkg::OUT_VAL_W-1:0] r_out_value, n_out_value;
    logic                       r_out_last, n_out_last;

    // Combinational helpers.
    logic [TW:0]                div_trial;
    logic                       div_ge;
    logic signed [SW:0]         sum_ext;
    logic                       past_end;
    logic [SW-1:0]              sum_mag;
    logic [SW-VW:0]             quo_upper;
    logic [LW:0]                ec_inc;
    logic                       can_push;
    logic                       out_free;
    logic                       in_accept;

    function automatic logic signed [VW-1:0] sat_sum(input logic signed [SW-1:0] x);
        logic [SW-VW:0] upper;
        upper = x[SW-1:VW-1];
        if ((&upper) || !(|upper)) begin
            return x[VW-1:0];
        end else if (x[SW-1]) begin
            return VAL_MIN;
        end else begin
            return VAL_MAX;
        end
    endfunction

    assign o_in_stall    = (r_state != S_IDLE);
    assign in_accept     = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_time    = r_out_time;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign div_trial = {r_rem, r_quo[SW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_divisor});

    assign sum_ext   = (SW+1)'(r_sum) + (SW+1)'(r_v);
    assign past_end  = ({1'b0, r_t} >= ({1'b0, r_start} + (TW+1)'(r_secs)));
    assign sum_mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
    assign quo_upper = r_quo[SW-1:VW-1];
    assign ec_inc    = {1'b0, r_ec} + (LW+1)'(1);
    assign can_push  = (r_ec < r_limit);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_open      = r_open;
        n_ec        = r_ec;
        n_out_valid = r_out_valid && i_out_stall;
        n_t         = r_t;
        n_v         = r_v;
        n_eod       = r_eod;
        n_raw       = r_raw;
        n_secs      = r_secs;
        n_more      = r_more;
        n_start     = r_start;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_count     = r_count;
        n_first     = r_first;
        n_last_t    = r_last_t;
        n_res_time  = r_res_time;
        n_res_val   = r_res_val;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_divisor   = r_divisor;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_time  = r_out_time;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_t      = i_sample_time;
                    n_v      = VW'(i_sample_value);
                    n_eod    = i_end_of_data;
                    n_raw    = (r_bucket == '0) || (r_mode == tba_pkg::MODE_RAW);
                    n_secs   = tba_pkg::SECS_W'(r_bucket) *
                               tba_pkg::SECS_W'(tba_pkg::SECS_PER_MIN);
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_raw) begin
                    n_res_time = r_t;
                    n_res_val  = r_v;
                    n_more     = 1'b0;
                    n_ret      = r_eod ? S_CLOSE : S_IDLE;
                    n_state    = S_PUSH;
                end else if (!r_open) begin
                    n_state = S_ALIGN_LD;
                end else if (past_end) begin
                    // Reduce the old window first, then open the new one around this sample.
                    n_more  = r_eod;
                    n_ret   = S_ALIGN_LD;
                    n_state = S_EMIT;
                end else begin
                    if (sum_ext[SW] != sum_ext[SW-1]) begin
                        n_sum = sum_ext[SW] ? SUM_MIN : SUM_MAX;
                    end else begin
                        n_sum = sum_ext[SW-1:0];
                    end
                    if (r_v < r_min) begin
                        n_min = r_v;
                    end
                    if (r_v > r_max) begin
                        n_max = r_v;
                    end
                    if (r_count != '1) begin
                        n_count = r_count + TW'(1);
                    end
                    n_last_t = r_t;
                    n_state  = S_EOD;
                end
            end
            S_ALIGN_LD: begin
                n_rem     = '0;
                n_quo     = {r_t, {(SW-TW){1'b0}}};
                n_divisor = TW'(r_secs);
                n_cnt     = tba_pkg::CNT_W'(tba_pkg::ALIGN_STEPS);
                n_state   = S_ALIGN;
            end
            S_ALIGN, S_AVG: begin
                n_rem = div_ge ? TW'(div_trial - {1'b0, r_divisor}) : div_trial[TW-1:0];
                n_quo = {r_quo[SW-2:0], div_ge};
                n_cnt = r_cnt - tba_pkg::CNT_W'(1);
                if (r_cnt == tba_pkg::CNT_W'(1)) begin
                    n_state = (r_state == S_ALIGN) ? S_OPEN : S_AVG_FIN;
                end
            end
            S_OPEN: begin
                // The remainder of the alignment division is the offset into the window.
                n_start  = r_t - r_rem;
                n_open   = 1'b1;
                n_sum    = SW'(r_v);
                n_min    = r_v;
                n_max    = r_v;
                n_count  = TW'(1);
                n_first  = r_t;
                n_last_t = r_t;
                n_state  = S_EOD;
            end
            S_EOD: begin
                if (r_eod) begin
                    n_more  = 1'b0;
                    n_ret   = S_CLOSE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                case (r_mode)
                    tba_pkg::MODE_MIN: begin
                        n_res_time = r_first;
                        n_res_val  = r_min;
                        n_state    = S_PUSH;
                    end
                    tba_pkg::MODE_MAX: begin
                        n_res_time = r_first;
                        n_res_val  = r_max;
                        n_state    = S_PUSH;
                    end
                    tba_pkg::MODE_SUM: begin
                        n_res_time = r_last_t;
                        n_res_val  = sat_sum(r_sum);
                        n_state    = S_PUSH;
                    end
                    default: begin
                        // Average: divide the magnitude, restore the sign afterwards.
                        n_neg     = r_sum[SW-1];
                        n_rem     = '0;
                        n_quo     = sum_mag;
                        n_divisor = (r_count == '0) ? TW'(1) : r_count;
                        n_cnt     = tba_pkg::CNT_W'(tba_pkg::AVG_STEPS);
                        n_state   = S_AVG;
                    end
                endcase
            end
            S_AVG_FIN: begin
                n_res_time = r_start + TW'(r_secs >> 1);
                if (|quo_upper) begin
                    n_res_val = r_neg ? VAL_MIN : VAL_MAX;
                end else if (r_neg) begin
                    n_res_val = VW'(-r_quo[VW-1:0]);
                end else begin
                    n_res_val = r_quo[VW-1:0];
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!can_push) begin
                    n_state = r_ret;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_res_time;
                    n_out_value = tba_pkg::OUT_VAL_W'(r_res_val);
                    n_out_last  = !(r_more && (ec_inc < {1'b0, r_limit}));
                    n_ec        = ec_inc[LW-1:0];
                    n_state     = r_ret;
                end
            end
            S_CLOSE: begin
                n_open  = 1'b0;
                n_ec    = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_open      <= 1'b0;
            r_ec        <= '0;
            r_out_valid <= 1'b0;
            r_bucket    <= '0;
            r_mode      <= tba_pkg::MODE_RAW;
            r_limit     <= LW'(tba_pkg::LIMIT_RESET);
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_open      <= n_open;
            r_ec        <= n_ec;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tba_pkg::CFG_BUCKET: r_bucket <= i_cfg_data[tba_pkg::BUCKET_W-1:0];
                    tba_pkg::CFG_MODE:   r_mode   <= i_cfg_data[tba_pkg::MODE_W-1:0];
                    tba_pkg::CFG_LIMIT: begin
                        r_limit <= LW'(i_cfg_data[tba_pkg::LIMIT_FIELD_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_v         <= n_v;
        r_eod       <= n_eod;
        r_raw       <= n_raw;
        r_secs      <= n_secs;
        r_more      <= n_more;
        r_start     <= n_start;
        r_sum       <= n_sum;
        r_min       <= n_min;
        r_max       <= n_max;
        r_count     <= n_count;
        r_first     <= n_first;
        r_last_t    <= n_last_t;
        r_res_time  <= n_res_time;
        r_res_val   <= n_res_val;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_divisor   <= n_divisor;
        r_cnt       <= n_cnt;
        r_neg       <= n_neg;
        r_out_time  <= n_out_time;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

endmodule

// ----- rtl/tba_checker.sv -----
`include "time_bucket_aggregator_macros.svh"

module tba_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic        [tba_pkg::TIME_W-1:0]     i_sample_time,
    input logic signed [tba_pkg::IN_VAL_W-1:0]   i_sample_value,
    input logic                                  i_end_of_data,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic        [tba_pkg::TIME_W-1:0]     o_out_time,
    input logic signed [tba_pkg::OUT_VAL_W-1:0]  o_out_value,
    input logic                                  o_last_of_run,
    input logic                                  i_cfg_we,
    input logic        [tba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic        [tba_pkg::CFG_W-1:0]      i_cfg_data
);

    // An accepted sample always makes the block busy in the next cycle.
    `TBA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "block took a second word without working on the first")

    // A new output word is only loaded while the block is working on a sample.
    `TBA_ASSERT_NOW(a_word_from_work, $rose(o_out_valid), $past(o_in_stall), "output word appeared while the block was idle")

    // A stalled output word stays put.
    `TBA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_time) && $stable(o_out_value) && $stable(o_last_of_run), "stalled output word changed")

endmodule

bind time_bucket_aggregator tba_checker u_tba_checker (.*);
